// ===== src/assert_macros.svh =====
// Assertion macros shared by the feedback decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/mfd_pkg.sv =====
// Types and constants of the motor feedback frame decoder.
`default_nettype none

package mfd_pkg;

  localparam int unsigned IdW       = 4;
  localparam int unsigned AngleW    = 16;
  localparam int unsigned CodeW     = 12;
  localparam int unsigned TempW     = 8;
  localparam int unsigned TurnW     = 16;
  localparam int unsigned PosW      = 32;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 112;

  // Angle is taken as offset binary around mid scale.
  localparam logic [PosW-1:0] AngleMid = PosW'(32767);
  // Half a turn in signed 17-bit delta units.
  localparam logic signed [AngleW:0] HalfTurn = 17'sd32768;

  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_TICK  = 1'b1
  } action_e;

  typedef enum logic {
    CFG_MOTOR_ID = 1'b0,
    CFG_UNWRAP   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                    kind;
    logic                    online;
    logic signed [PosW-1:0]  total_position;
    logic signed [TurnW-1:0] turn_count;
    logic [TempW-1:0]        rotor_temp;
    logic [TempW-1:0]        driver_temp;
    logic [CodeW-1:0]        torque_raw;
    logic [CodeW-1:0]        speed_raw;
    logic [AngleW-1:0]       angle_raw;
    logic [3:0]              status_code;
    logic                    id_match;
  } res_t;

endpackage

`default_nettype wire

// ===== src/motor_feedback_frame_decoder.sv =====
// Top level of the motor feedback frame decoder.
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tuser: action, tdata: frame bytes
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tuser: kind, tdata: decoded fields
//  cfg       in   cfg_we_i (no handshake back)     cfg_idx_i, cfg_data_i
//
//  One beat in per cycle while s_axis_tready_o is high; when m_axis is not
//  stalled, its result appears on m_axis the next cycle, from the result register after the decode logic.
//  Reset restores motor_id 1, unwrap off, clears angle/turn/alive state.
//  A stalled m_axis fills the skid entry; s_axis_tready_o drops only when
//  both the result register and the skid entry hold beats.
`default_nettype none

module motor_feedback_frame_decoder (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // config write port
  input  wire                            cfg_we_i,
  input  wire                            cfg_idx_i,    // 0 motor_id, 1 unwrap_enable
  input  wire  [mfd_pkg::IdW-1:0]        cfg_data_i,
  // input stream
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire  [mfd_pkg::InDataW-1:0]    s_axis_tdata_i,  // frame_data[63:0]
  input  wire                            s_axis_tuser_i,  // action
  // result stream
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  // [0] id_match, [4:1] status_code, [20:5] angle_raw, [32:21] speed_raw,
  // [44:33] torque_raw, [52:45] driver_temp, [60:53] rotor_temp,
  // [76:61] turn_count, [108:77] total_position, [109] online, [111:110] zero
  output logic [mfd_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                           m_axis_tuser_o   // kind
);
  import mfd_pkg::*;

  res_t core_res;
  res_t out_res;
  logic push;

  // State advances only on an accepted beat.
  assign push = s_axis_tvalid_i && s_axis_tready_o;

  mfd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .action_i   (s_axis_tuser_i),
    .frame_i    (s_axis_tdata_i),
    .res_o      (core_res)
  );

  mfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_res_i    (core_res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res)
  );

  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tdata_o = {2'b00,
                           out_res.online,
                           out_res.total_position,
                           out_res.turn_count,
                           out_res.rotor_temp,
                           out_res.driver_temp,
                           out_res.torque_raw,
                           out_res.speed_raw,
                           out_res.angle_raw,
                           out_res.status_code,
                           out_res.id_match};

endmodule

`default_nettype wire

// ===== src/mfd_core.sv =====
// Frame decode, turn unwrap and alive tracking; one accepted beat (push_i) per cycle.
`default_nettype none

module mfd_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire                          cfg_idx_i,
  input  wire  [mfd_pkg::IdW-1:0]      cfg_data_i,
  input  wire                          push_i,
  input  wire                          action_i,
  input  wire  [mfd_pkg::InDataW-1:0]  frame_i,
  output mfd_pkg::res_t                res_o
);
  import mfd_pkg::*;

  logic [IdW-1:0]          motor_id_q;
  logic                    unwrap_q;
  logic [AngleW-1:0]       prev_angle_q, prev_angle_d;
  logic [TurnW-1:0]        turns_q, turns_d;
  logic                    seeded_q, seeded_d;
  logic                    frame_seen_q, frame_seen_d;
  logic                    online_q, online_d;

  logic                    is_tick;
  logic                    match;
  logic [AngleW-1:0]       angle;
  logic [AngleW-1:0]       ref_angle;
  logic signed [AngleW:0]  delta;
  logic [PosW-1:0]         total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_id_q <= IdW'(1);
      unwrap_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MOTOR_ID: motor_id_q <= cfg_data_i;
        CFG_UNWRAP:   unwrap_q   <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  assign is_tick = (action_e'(action_i) == ACT_TICK);
  assign match   = !is_tick && (frame_i[3:0] == motor_id_q);
  assign angle   = {frame_i[15:8], frame_i[23:16]};
  // First matching frame compares against itself: zero delta.
  assign ref_angle = seeded_q ? prev_angle_q : angle;
  assign delta     = $signed({1'b0, angle}) - $signed({1'b0, ref_angle});

  always_comb begin
    turns_d = turns_q;
    if (!unwrap_q) begin
      turns_d = '0;
    end else if (delta < -HalfTurn) begin
      turns_d = turns_q + TurnW'(1);
    end else if (delta > HalfTurn) begin
      turns_d = turns_q - TurnW'(1);
    end
  end

  assign total = {turns_d, {AngleW{1'b0}}} + PosW'(angle) - AngleMid;

  always_comb begin
    prev_angle_d = prev_angle_q;
    seeded_d     = seeded_q;
    frame_seen_d = frame_seen_q;
    online_d     = online_q;
    if (is_tick) begin
      online_d     = frame_seen_q;
      frame_seen_d = 1'b0;
    end else begin
      frame_seen_d = 1'b1;
      if (match) begin
        prev_angle_d = angle;
        seeded_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_angle_q <= '0;
      turns_q      <= '0;
      seeded_q     <= 1'b0;
      frame_seen_q <= 1'b0;
      online_q     <= 1'b0;
    end else if (push_i) begin
      prev_angle_q <= prev_angle_d;
      if (match) begin
        turns_q <= turns_d;
      end
      seeded_q     <= seeded_d;
      frame_seen_q <= frame_seen_d;
      online_q     <= online_d;
    end
  end

  always_comb begin
    res_o        = '0;
    res_o.kind   = is_tick;
    res_o.online = online_d;
    if (match) begin
      res_o.id_match       = 1'b1;
      res_o.status_code    = frame_i[7:4];
      res_o.angle_raw      = angle;
      res_o.speed_raw      = {frame_i[31:24], frame_i[39:36]};
      res_o.torque_raw     = {frame_i[35:32], frame_i[47:40]};
      res_o.driver_temp    = frame_i[55:48];
      res_o.rotor_temp     = frame_i[63:56];
      res_o.turn_count     = turns_d;
      res_o.total_position = total;
    end
  end

`include "assert_macros.svh"
  `ASSERT_NEXT(a_tick_clears_seen, clk_i, rst_ni, push_i && is_tick, !frame_seen_q)
  `ASSERT_NEXT(a_frame_sets_seen, clk_i, rst_ni, push_i && !is_tick, frame_seen_q)
  `ASSERT_NEXT(a_no_unwrap_zero, clk_i, rst_ni, push_i && match && !unwrap_q, turns_q == '0)

endmodule

`default_nettype wire

// ===== src/mfd_out_buf.sv =====
// Result register with one skid entry between decode and the output stream.
`default_nettype none

module mfd_out_buf (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  mfd_pkg::res_t  in_res_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output mfd_pkg::res_t  out_res_o
);
  import mfd_pkg::*;

  logic  out_vld_q, out_vld_d;
  logic  skid_vld_q, skid_vld_d;
  res_t  out_q, out_d;
  res_t  skid_q, skid_d;
  logic  push, pop;

  assign in_ready_o  = !skid_vld_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_vld_q && out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else if (push) begin
        out_d     = in_res_i;
        out_vld_d = 1'b1;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (push) begin
      skid_d     = in_res_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`include "assert_macros.svh"
  `ASSERT_IMPLY(a_skid_behind_out, clk_i, rst_ni, skid_vld_q, out_vld_q)
  `ASSERT_NEXT(a_skid_kept, clk_i, rst_ni, skid_vld_q && !out_ready_i, skid_vld_q)
  `ASSERT_NEXT(a_push_lands, clk_i, rst_ni, push, out_vld_q)

endmodule

`default_nettype wire
